@@ hdl/cpb_pkg.sv @@
// Shared constants, register codes and word types of the capture point bound block
`timescale 1ns / 1ps
package cpb_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DATA_W    = 32;
  localparam int OUT_W     = 48;
  localparam int DT_W      = 25;
  localparam int G_W       = 28;
  localparam int IDX_W     = 3;

  localparam logic [DT_W-1:0] DT_RESET = DT_W'(16777);
  localparam logic [G_W-1:0]  G_RESET  = G_W'(164573020);

  localparam int QT_W   = G_W + 2 * FRAC_BITS;
  localparam int ROOT_W = QT_W / 2;
  localparam int SR_W   = ROOT_W + 2;

  localparam int LIM_W  = DATA_W + 1;
  localparam int VDT_W  = DATA_W + DT_W + 1;
  localparam int E_W    = DATA_W + FRAC_BITS + 4;
  localparam int ELO_W  = E_W / 2;
  localparam int EHI_W  = E_W - ELO_W;
  localparam int PLO_W  = ELO_W + ROOT_W;
  localparam int PHI_W  = EHI_W + ROOT_W + 1;
  localparam int P_W    = E_W + ROOT_W + 2;

  localparam int WDT_W  = ROOT_W + DT_W;
  localparam int WDT2_W = WDT_W + 1;
  localparam int DLO_W  = WDT2_W / 2;
  localparam int DHI_W  = WDT2_W - DLO_W;
  localparam int DEN_W  = WDT2_W + DT_W;

  localparam int QB     = 2 * DATA_W - 2;
  localparam int LOWD   = QB - FRAC_BITS - 1;
  localparam int CMP_W  = DEN_W + LOWD;
  localparam int MAG_W  = QB + 1;
  localparam int VAL_W  = MAG_W + 1;
  localparam int DIFF_W = VAL_W + 1;

  localparam int POST_LAT = 6;
  localparam int LANE_LAT = QB + 3;
  localparam int NLANE    = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_SX_MIN,
    REG_SX_MAX,
    REG_SY_MIN,
    REG_SY_MAX,
    REG_MARGIN_X,
    REG_MARGIN_Y,
    REG_TIME_STEP,
    REG_GRAVITY
  } cpb_reg_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic                     err;
  } cpb_item_t;

  typedef struct packed {
    logic                     neg;
    logic [P_W-1:0]           mag;
    logic [DEN_W-1:0]         den;
    logic signed [DATA_W-1:0] drift;
    logic                     err;
  } cpb_lane_in_t;

endpackage

@@ hdl/cpb_in_if.sv @@
// Input word channel: valid, ready and the state sample
`timescale 1ns / 1ps
interface cpb_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [cpb_pkg::DATA_W-1:0] com_x;
  logic signed [cpb_pkg::DATA_W-1:0] com_y;
  logic signed [cpb_pkg::DATA_W-1:0] com_height;
  logic signed [cpb_pkg::DATA_W-1:0] vel_x;
  logic signed [cpb_pkg::DATA_W-1:0] vel_y;
  logic signed [cpb_pkg::DATA_W-1:0] drift_x;
  logic signed [cpb_pkg::DATA_W-1:0] drift_y;

  modport source (output valid, com_x, com_y, com_height, vel_x, vel_y, drift_x, drift_y,
                  input ready);
  modport sink   (input valid, com_x, com_y, com_height, vel_x, vel_y, drift_x, drift_y,
                  output ready);
endinterface

@@ hdl/cpb_out_if.sv @@
// Output word channel: valid, ready and the four bounds with the height flag
`timescale 1ns / 1ps
interface cpb_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [cpb_pkg::OUT_W-1:0] lower_x;
  logic signed [cpb_pkg::OUT_W-1:0] upper_x;
  logic signed [cpb_pkg::OUT_W-1:0] lower_y;
  logic signed [cpb_pkg::OUT_W-1:0] upper_y;
  logic                            height_error;

  modport source (output valid, lower_x, upper_x, lower_y, upper_y, height_error,
                  input ready);
  modport sink   (input valid, lower_x, upper_x, lower_y, upper_y, height_error,
                  output ready);
endinterface

@@ hdl/capture_point_bound_calc_top.sv @@
// Top level of the capture point bound block: config registers, setup stages and lanes
//
// Input words arrive on in_i (valid/ready); each carries the center of mass position,
// height, horizontal velocity and drift. Result words leave on out_o with the lower
// and upper acceleration bounds per axis and a height error flag (bounds zero then).
// The support rectangle, margins, time step and gravity are written through cfg_we_i /
// cfg_idx_i / cfg_wdata_i; the user must do so while no word is in flight (unchecked).
// From acceptance to out_o.valid a word passes 76 stages of the gravity over height
// divider, 38 square root stages, 6 setup stages and the bound lanes, whose depth is
// set by the 62 quotient bits of the per lane bound divider. Throughput is one word
// per cycle while the pipeline is not stalled; every stage moves one word per clock
// when it advances. Reset clears all stage valid bits and loads the config defaults
// (1 ms step, gravity of about 9.809, zero rectangle and margins).
// When the receiver holds out_o.ready low with a word waiting, the whole pipeline
// holds in place and in_i.ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
module capture_point_bound_calc_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cpb_in_if.sink                        in_i,
  cpb_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [cpb_pkg::IDX_W-1:0]     cfg_idx_i,
  input  logic [cpb_pkg::DATA_W-1:0]    cfg_wdata_i
);

  typedef struct packed {
    cpb_pkg::cpb_item_t                        item;
    logic [cpb_pkg::ROOT_W-1:0]                w;
    logic [cpb_pkg::WDT_W-1:0]                 wdt;
    logic [1:0][cpb_pkg::VDT_W-1:0]            vdt;
    logic [cpb_pkg::NLANE-1:0][cpb_pkg::LIM_W-1:0] lim;
  } s1_t;

  typedef struct packed {
    cpb_pkg::cpb_item_t                        item;
    logic [cpb_pkg::ROOT_W-1:0]                w;
    logic [cpb_pkg::WDT2_W-1:0]                wdt2;
    logic [cpb_pkg::NLANE-1:0][cpb_pkg::E_W-1:0] e;
  } s2_t;

  typedef struct packed {
    cpb_pkg::cpb_item_t                          item;
    logic [cpb_pkg::NLANE-1:0][cpb_pkg::PLO_W-1:0] plo;
    logic [cpb_pkg::NLANE-1:0][cpb_pkg::PHI_W-1:0] phi;
    logic [cpb_pkg::DLO_W+cpb_pkg::DT_W-1:0]     dlo;
    logic [cpb_pkg::DHI_W+cpb_pkg::DT_W-1:0]     dhi;
  } s3_t;

  typedef struct packed {
    cpb_pkg::cpb_item_t                        item;
    logic [cpb_pkg::NLANE-1:0][cpb_pkg::P_W-1:0] p;
    logic [cpb_pkg::DEN_W-1:0]                 den;
  } s4_t;

  logic [cpb_pkg::DATA_W-1:0] sx_min_q, sx_max_q, sy_min_q, sy_max_q, mgx_q, mgy_q;
  logic [cpb_pkg::DT_W-1:0]   dt_q;
  logic [cpb_pkg::G_W-1:0]    g_q;
  logic [cpb_pkg::DT_W-1:0]   dte;

  logic                       adv;
  cpb_pkg::cpb_item_t         in_item;
  logic [cpb_pkg::DATA_W-1:0] in_h;

  logic                       r_vld;
  cpb_pkg::cpb_item_t         r_item;
  logic [cpb_pkg::ROOT_W-1:0] r_w;

  logic [cpb_pkg::POST_LAT-1:0] pv_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q, s5_d, s5_q;
  cpb_pkg::cpb_lane_in_t [cpb_pkg::NLANE-1:0] s6_d, s6_q;

  logic [cpb_pkg::LANE_LAT-1:0] lv_q;
  logic [cpb_pkg::LANE_LAT-1:0] le_q;
  logic signed [cpb_pkg::OUT_W-1:0] res [cpb_pkg::NLANE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_min_q <= '0;
      sx_max_q <= '0;
      sy_min_q <= '0;
      sy_max_q <= '0;
      mgx_q    <= '0;
      mgy_q    <= '0;
      dt_q     <= cpb_pkg::DT_RESET;
      g_q      <= cpb_pkg::G_RESET;
    end else if (cfg_we_i) begin
      unique case (cpb_pkg::cpb_reg_e'(cfg_idx_i))
        cpb_pkg::REG_SX_MIN:    sx_min_q <= cfg_wdata_i;
        cpb_pkg::REG_SX_MAX:    sx_max_q <= cfg_wdata_i;
        cpb_pkg::REG_SY_MIN:    sy_min_q <= cfg_wdata_i;
        cpb_pkg::REG_SY_MAX:    sy_max_q <= cfg_wdata_i;
        cpb_pkg::REG_MARGIN_X:  mgx_q    <= cfg_wdata_i;
        cpb_pkg::REG_MARGIN_Y:  mgy_q    <= cfg_wdata_i;
        cpb_pkg::REG_TIME_STEP: dt_q     <= cfg_wdata_i[cpb_pkg::DT_W-1:0];
        cpb_pkg::REG_GRAVITY:   g_q      <= cfg_wdata_i[cpb_pkg::G_W-1:0];
        default: ;
      endcase
    end
  end

  assign dte = (dt_q == '0) ? cpb_pkg::DT_W'(1) : dt_q;

  assign adv        = !lv_q[cpb_pkg::LANE_LAT-1] || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    in_item.px  = in_i.com_x;
    in_item.py  = in_i.com_y;
    in_item.vx  = in_i.vel_x;
    in_item.vy  = in_i.vel_y;
    in_item.ax  = in_i.drift_x;
    in_item.ay  = in_i.drift_y;
    in_item.err = in_i.com_height <= 0;
    in_h        = in_item.err ? cpb_pkg::DATA_W'(1) : in_i.com_height;
  end

  cpb_rate u_rate (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (in_i.valid),
    .item_i    (in_item),
    .height_i  (in_h),
    .gravity_i (g_q),
    .vld_o     (r_vld),
    .item_o    (r_item),
    .rate_o    (r_w)
  );

  always_comb begin
    s1_d.item   = r_item;
    s1_d.w      = r_w;
    s1_d.wdt    = r_w * dte;
    s1_d.vdt[0] = $signed(r_item.vx) * $signed({1'b0, dte});
    s1_d.vdt[1] = $signed(r_item.vy) * $signed({1'b0, dte});
    s1_d.lim[0] = $signed(sx_min_q) + $signed(mgx_q);
    s1_d.lim[1] = $signed(sx_max_q) - $signed(mgx_q);
    s1_d.lim[2] = $signed(sy_min_q) + $signed(mgy_q);
    s1_d.lim[3] = $signed(sy_max_q) - $signed(mgy_q);
  end

  always_comb begin
    s2_d.item = s1_q.item;
    s2_d.w    = s1_q.w;
    s2_d.wdt2 = cpb_pkg::WDT2_W'(s1_q.wdt) + (cpb_pkg::WDT2_W'(1) << (2 * cpb_pkg::FRAC_BITS + 1));
    for (int k = 0; k < cpb_pkg::NLANE; k++) begin
      s2_d.e[k] = (($signed(s1_q.lim[k]) - $signed((k < 2) ? s1_q.item.px : s1_q.item.py))
                   <<< cpb_pkg::FRAC_BITS) - $signed(s1_q.vdt[k/2]);
    end
  end

  always_comb begin
    s3_d.item = s2_q.item;
    for (int k = 0; k < cpb_pkg::NLANE; k++) begin
      s3_d.plo[k] = s2_q.e[k][cpb_pkg::ELO_W-1:0] * s2_q.w;
      s3_d.phi[k] = $signed(s2_q.e[k][cpb_pkg::E_W-1:cpb_pkg::ELO_W]) * $signed({1'b0, s2_q.w});
    end
    s3_d.dlo = s2_q.wdt2[cpb_pkg::DLO_W-1:0] * dte;
    s3_d.dhi = s2_q.wdt2[cpb_pkg::WDT2_W-1:cpb_pkg::DLO_W] * dte;
  end

  always_comb begin
    s4_d.item = s3_q.item;
    for (int k = 0; k < cpb_pkg::NLANE; k++) begin
      s4_d.p[k] = ($signed(cpb_pkg::P_W'($signed(s3_q.phi[k]))) <<< cpb_pkg::ELO_W) +
                  $signed(cpb_pkg::P_W'(s3_q.plo[k]));
    end
    s4_d.den = (cpb_pkg::DEN_W'(s3_q.dhi) << cpb_pkg::DLO_W) + cpb_pkg::DEN_W'(s3_q.dlo);
  end

  always_comb begin
    s5_d.item = s4_q.item;
    s5_d.den  = s4_q.den;
    for (int k = 0; k < cpb_pkg::NLANE; k++) begin
      s5_d.p[k] = $signed(s4_q.p[k]) -
                  ($signed(cpb_pkg::P_W'($signed((k < 2) ? s4_q.item.vx : s4_q.item.vy)))
                   <<< (2 * cpb_pkg::FRAC_BITS));
    end
  end

  always_comb begin
    for (int k = 0; k < cpb_pkg::NLANE; k++) begin
      s6_d[k].neg   = s5_q.p[k][cpb_pkg::P_W-1];
      s6_d[k].mag   = s5_q.p[k][cpb_pkg::P_W-1] ? cpb_pkg::P_W'(-$signed(s5_q.p[k])) : s5_q.p[k];
      s6_d[k].den   = s5_q.den;
      s6_d[k].drift = (k < 2) ? s5_q.item.ax : s5_q.item.ay;
      s6_d[k].err   = s5_q.item.err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      lv_q <= '0;
    end else if (adv) begin
      pv_q <= {pv_q[cpb_pkg::POST_LAT-2:0], r_vld};
      lv_q <= {lv_q[cpb_pkg::LANE_LAT-2:0], pv_q[cpb_pkg::POST_LAT-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      le_q <= {le_q[cpb_pkg::LANE_LAT-2:0], s6_q[0].err};
    end
  end

  for (genvar k = 0; k < cpb_pkg::NLANE; k++) begin : g_lane
    cpb_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .lane_i (s6_q[k]),
      .res_o  (res[k])
    );
  end

  assign out_o.valid        = lv_q[cpb_pkg::LANE_LAT-1];
  assign out_o.lower_x      = res[0];
  assign out_o.upper_x      = res[1];
  assign out_o.lower_y      = res[2];
  assign out_o.upper_y      = res[3];
  assign out_o.height_error = le_q[cpb_pkg::LANE_LAT-1];

endmodule

@@ hdl/cpb_rate.sv @@
// Pipelined natural rate: restoring divide of g by height, then restoring square root
`timescale 1ns / 1ps
module cpb_rate (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          vld_i,
  input  cpb_pkg::cpb_item_t            item_i,
  input  logic [cpb_pkg::DATA_W-1:0]    height_i,
  input  logic [cpb_pkg::G_W-1:0]       gravity_i,
  output logic                          vld_o,
  output cpb_pkg::cpb_item_t            item_o,
  output logic [cpb_pkg::ROOT_W-1:0]    rate_o
);

  logic                           dv_q   [cpb_pkg::QT_W];
  cpb_pkg::cpb_item_t             dit_q  [cpb_pkg::QT_W];
  logic [cpb_pkg::DATA_W-1:0]     dh_q   [cpb_pkg::QT_W];
  logic [cpb_pkg::DATA_W-1:0]     drem_q [cpb_pkg::QT_W];
  logic [cpb_pkg::QT_W-1:0]       dquo_q [cpb_pkg::QT_W];

  logic                           sv_q    [cpb_pkg::ROOT_W];
  cpb_pkg::cpb_item_t             sit_q   [cpb_pkg::ROOT_W];
  logic [cpb_pkg::QT_W-1:0]       srad_q  [cpb_pkg::ROOT_W];
  logic [cpb_pkg::SR_W-1:0]       srem_q  [cpb_pkg::ROOT_W];
  logic [cpb_pkg::ROOT_W-1:0]     sroot_q [cpb_pkg::ROOT_W];

  for (genvar j = 0; j < cpb_pkg::QT_W; j++) begin : g_div
    localparam int I = cpb_pkg::QT_W - 1 - j;
    logic                       src_v;
    cpb_pkg::cpb_item_t         src_it;
    logic [cpb_pkg::DATA_W-1:0] src_h;
    logic [cpb_pkg::DATA_W-1:0] src_rem;
    logic [cpb_pkg::QT_W-1:0]   src_quo;
    logic                       dbit;
    logic [cpb_pkg::DATA_W:0]   trial;
    logic                       ge;

    if (j == 0) begin : g_src
      assign src_v   = vld_i;
      assign src_it  = item_i;
      assign src_h   = height_i;
      assign src_rem = '0;
      assign src_quo = '0;
    end else begin : g_src
      assign src_v   = dv_q[j-1];
      assign src_it  = dit_q[j-1];
      assign src_h   = dh_q[j-1];
      assign src_rem = drem_q[j-1];
      assign src_quo = dquo_q[j-1];
    end

    if (I >= 2 * cpb_pkg::FRAC_BITS) begin : g_bit
      assign dbit = gravity_i[I-2*cpb_pkg::FRAC_BITS];
    end else begin : g_bit
      assign dbit = 1'b0;
    end

    assign trial = {src_rem, dbit};
    assign ge    = trial >= {1'b0, src_h};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j] <= 1'b0;
      end else if (adv_i) begin
        dv_q[j] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        dit_q[j]  <= src_it;
        dh_q[j]   <= src_h;
        drem_q[j] <= ge ? cpb_pkg::DATA_W'(trial - {1'b0, src_h}) : trial[cpb_pkg::DATA_W-1:0];
        dquo_q[j] <= {src_quo[cpb_pkg::QT_W-2:0], ge};
      end
    end
  end

  for (genvar k = 0; k < cpb_pkg::ROOT_W; k++) begin : g_sqrt
    localparam int I = cpb_pkg::QT_W - 1 - 2 * k;
    logic                         src_v;
    cpb_pkg::cpb_item_t           src_it;
    logic [cpb_pkg::QT_W-1:0]     src_rad;
    logic [cpb_pkg::SR_W-1:0]     src_rem;
    logic [cpb_pkg::ROOT_W-1:0]   src_root;
    logic [cpb_pkg::SR_W+1:0]     sh;
    logic [cpb_pkg::SR_W+1:0]     tr;
    logic                         ge;

    if (k == 0) begin : g_src
      assign src_v    = dv_q[cpb_pkg::QT_W-1];
      assign src_it   = dit_q[cpb_pkg::QT_W-1];
      assign src_rad  = dquo_q[cpb_pkg::QT_W-1];
      assign src_rem  = '0;
      assign src_root = '0;
    end else begin : g_src
      assign src_v    = sv_q[k-1];
      assign src_it   = sit_q[k-1];
      assign src_rad  = srad_q[k-1];
      assign src_rem  = srem_q[k-1];
      assign src_root = sroot_q[k-1];
    end

    assign sh = {src_rem, src_rad[I -: 2]};
    assign tr = (cpb_pkg::SR_W + 2)'({src_root, 2'b01});
    assign ge = sh >= tr;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[k] <= 1'b0;
      end else if (adv_i) begin
        sv_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        sit_q[k]   <= src_it;
        srad_q[k]  <= src_rad;
        srem_q[k]  <= ge ? cpb_pkg::SR_W'(sh - tr) : sh[cpb_pkg::SR_W-1:0];
        sroot_q[k] <= {src_root[cpb_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign vld_o  = sv_q[cpb_pkg::ROOT_W-1];
  assign item_o = sit_q[cpb_pkg::ROOT_W-1];
  assign rate_o = sroot_q[cpb_pkg::ROOT_W-1];

endmodule

@@ hdl/cpb_lane.sv @@
// One bound lane: pipelined floor division, clamp, drift subtract and output saturation
`timescale 1ns / 1ps
module cpb_lane (
  input  logic                             clk_i,
  input  logic                             adv_i,
  input  cpb_pkg::cpb_lane_in_t            lane_i,
  output logic signed [cpb_pkg::OUT_W-1:0] res_o
);

  typedef struct packed {
    logic                              neg;
    logic                              sat;
    logic                              err;
    logic signed [cpb_pkg::DATA_W-1:0] drift;
    logic [cpb_pkg::DEN_W-1:0]         den;
    logic [cpb_pkg::DEN_W-1:0]         rem;
    logic [cpb_pkg::LOWD-1:0]          dlow;
    logic [cpb_pkg::QB-1:0]            quo;
  } ls_t;

  ls_t                               ls_q [cpb_pkg::QB+1];
  ls_t                               ls0_d;
  logic [cpb_pkg::MAG_W-1:0]         mag;
  logic signed [cpb_pkg::VAL_W-1:0]  val_d;
  logic signed [cpb_pkg::VAL_W-1:0]  val_q;
  logic signed [cpb_pkg::DATA_W-1:0] drift_q;
  logic                              err_q;
  logic signed [cpb_pkg::DIFF_W-1:0] diff;
  logic signed [cpb_pkg::OUT_W-1:0]  res_d;
  logic signed [cpb_pkg::OUT_W-1:0]  res_q;

  always_comb begin
    ls0_d       = '0;
    ls0_d.neg   = lane_i.neg;
    ls0_d.err   = lane_i.err;
    ls0_d.drift = lane_i.drift;
    ls0_d.den   = lane_i.den;
    ls0_d.sat   = cpb_pkg::CMP_W'(lane_i.mag) >=
                  (cpb_pkg::CMP_W'(lane_i.den) << cpb_pkg::LOWD);
    ls0_d.rem   = cpb_pkg::DEN_W'(lane_i.mag >> cpb_pkg::LOWD);
    ls0_d.dlow  = lane_i.mag[cpb_pkg::LOWD-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ls_q[0] <= ls0_d;
    end
  end

  for (genvar j = 0; j < cpb_pkg::QB; j++) begin : g_step
    logic [cpb_pkg::DEN_W:0] trial;
    logic                    ge;
    ls_t                     nxt;

    assign trial = {ls_q[j].rem, ls_q[j].dlow[cpb_pkg::LOWD-1]};
    assign ge    = trial >= {1'b0, ls_q[j].den};

    always_comb begin
      nxt      = ls_q[j];
      nxt.rem  = ge ? cpb_pkg::DEN_W'(trial - {1'b0, ls_q[j].den}) : trial[cpb_pkg::DEN_W-1:0];
      nxt.dlow = {ls_q[j].dlow[cpb_pkg::LOWD-2:0], 1'b0};
      nxt.quo  = {ls_q[j].quo[cpb_pkg::QB-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        ls_q[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    if (ls_q[cpb_pkg::QB].sat) begin
      mag = cpb_pkg::MAG_W'(1) << cpb_pkg::QB;
    end else begin
      mag = cpb_pkg::MAG_W'(ls_q[cpb_pkg::QB].quo) +
            cpb_pkg::MAG_W'(ls_q[cpb_pkg::QB].neg && (ls_q[cpb_pkg::QB].rem != '0));
    end
    val_d = ls_q[cpb_pkg::QB].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      val_q   <= val_d;
      drift_q <= ls_q[cpb_pkg::QB].drift;
      err_q   <= ls_q[cpb_pkg::QB].err;
    end
  end

  always_comb begin
    diff = cpb_pkg::DIFF_W'(val_q) - cpb_pkg::DIFF_W'(drift_q);
    if (err_q) begin
      res_d = '0;
    end else if (diff[cpb_pkg::DIFF_W-1:cpb_pkg::OUT_W-1] == '0 ||
                 diff[cpb_pkg::DIFF_W-1:cpb_pkg::OUT_W-1] == '1) begin
      res_d = diff[cpb_pkg::OUT_W-1:0];
    end else begin
      res_d = {diff[cpb_pkg::DIFF_W-1], {(cpb_pkg::OUT_W-1){~diff[cpb_pkg::DIFF_W-1]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ hdl/cpb_checker.sv @@
// Port level checks of the capture point bound block and their bind to the top level
`timescale 1ns / 1ps
module cpb_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic                             height_error_i,
  input logic signed [cpb_pkg::OUT_W-1:0] lower_x_i,
  input logic signed [cpb_pkg::OUT_W-1:0] upper_x_i,
  input logic signed [cpb_pkg::OUT_W-1:0] lower_y_i,
  input logic signed [cpb_pkg::OUT_W-1:0] upper_y_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(lower_x_i) && $stable(upper_x_i) &&
                                    $stable(lower_y_i) && $stable(upper_y_i) &&
                                    $stable(height_error_i))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && height_error_i |-> lower_x_i == 0 && upper_x_i == 0 && lower_y_i == 0 &&
                                      upper_y_i == 0)
    else $error("height error word with nonzero bounds");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output drain");

  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> !in_ready_i || !$past(out_valid_i) || out_ready_i ||
                                  !out_valid_i)
    else $error("input ready rose without output progress");

endmodule

bind capture_point_bound_calc_top cpb_checker u_cpb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .height_error_i (out_o.height_error),
  .lower_x_i      (out_o.lower_x),
  .upper_x_i      (out_o.upper_x),
  .lower_y_i      (out_o.lower_y),
  .upper_y_i      (out_o.upper_y)
);
